// ===== hdl/rmq_pkg.sv =====
// shared types and constants for the rotation matrix to quaternion block
package rmq_pkg;

  localparam int ELEM_W    = 16;
  localparam int NUM_W     = ELEM_W + 2;
  localparam int MID_DEPTH = 4;

  typedef enum logic [1:0] {
    BR_TRACE = 2'd0,
    BR_X     = 2'd1,
    BR_Y     = 2'd2,
    BR_Z     = 2'd3
  } br_t;

  // classified request; n0..n2 feed the three non-diagonal parts in w,x,y,z order
  typedef struct packed {
    br_t                     br;
    logic                    deg;
    logic signed [NUM_W-1:0] n0;
    logic signed [NUM_W-1:0] n1;
    logic signed [NUM_W-1:0] n2;
  } rmq_tag_t;

  typedef struct packed {
    logic [ELEM_W-1:0] w;
    logic [ELEM_W-1:0] x;
    logic [ELEM_W-1:0] y;
    logic [ELEM_W-1:0] z;
    br_t               br;
    logic              deg;
  } rmq_result_t;

endpackage

// ===== hdl/rotation_matrix_to_quaternion.sv =====
// rotation matrix to quaternion converter, top level
//
// Input side is a queue: drive r00..r22 and push; a request is taken on a
// rising edge with push high and full low. Output side is a queue too: the
// oldest result sits on quat_w..quat_z, branch_taken and degenerate while
// empty is low, and is taken on a rising edge with pop high.
// One matrix can be taken every cycle while full is low and one result delivered every cycle while empty is low.
// The path from push to empty going low runs through the bit-per-stage square
// root (FRAC_BITS+9 stages) and the bit-per-stage dividers (FRAC_BITS+18
// stages) in series.
// A four-entry queue sits between classification and arithmetic; the result
// queue holds every request in flight, and the arithmetic pipe takes a new
// request only while a result slot is reserved for it. When the receiver
// stalls the result queue fills, then the front queue, then full rises.
// Synchronous reset empties both queues and the pipeline valids; no
// clearing pass is needed.
module rotation_matrix_to_quaternion #(
  parameter int FRAC_BITS = 14
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic signed [rmq_pkg::ELEM_W-1:0] r00,
  input  logic signed [rmq_pkg::ELEM_W-1:0] r01,
  input  logic signed [rmq_pkg::ELEM_W-1:0] r02,
  input  logic signed [rmq_pkg::ELEM_W-1:0] r10,
  input  logic signed [rmq_pkg::ELEM_W-1:0] r11,
  input  logic signed [rmq_pkg::ELEM_W-1:0] r12,
  input  logic signed [rmq_pkg::ELEM_W-1:0] r20,
  input  logic signed [rmq_pkg::ELEM_W-1:0] r21,
  input  logic signed [rmq_pkg::ELEM_W-1:0] r22,
  output logic                              empty,
  input  logic                              pop,
  output logic signed [rmq_pkg::ELEM_W-1:0] quat_w,
  output logic signed [rmq_pkg::ELEM_W-1:0] quat_x,
  output logic signed [rmq_pkg::ELEM_W-1:0] quat_y,
  output logic signed [rmq_pkg::ELEM_W-1:0] quat_z,
  output logic [1:0]                        branch_taken,
  output logic                              degenerate
);
  import rmq_pkg::*;

  localparam int RW        = FRAC_BITS + 18;
  localparam int LAT       = (FRAC_BITS + 9) + (FRAC_BITS + 18) + 3;
  localparam int OUT_DEPTH = 2 ** $clog2(LAT + 2);
  localparam int CAP       = OUT_DEPTH + 1;
  localparam int TW        = $bits(rmq_tag_t);
  localparam int QW        = TW + RW;

  rmq_tag_t             f_tag, b_tag;
  logic signed [RW-1:0] f_rad, b_rad;
  logic [QW-1:0]        q_dout;
  logic                 q_empty, q_pop;
  logic                 res_v, out_pop;
  rmq_result_t          res, head;

  rmq_front #(.FRAC_BITS(FRAC_BITS), .RW(RW)) u_front (
    .r00(r00), .r01(r01), .r02(r02),
    .r10(r10), .r11(r11), .r12(r12),
    .r20(r20), .r21(r21), .r22(r22),
    .tag(f_tag), .rad(f_rad)
  );

  rmq_queue #(.W(QW), .DEPTH(MID_DEPTH)) u_queue (
    .clk(clk), .rst(rst),
    .push(push), .din({f_tag, f_rad}), .full(full),
    .pop(q_pop), .empty(q_empty), .dout(q_dout)
  );

  assign b_tag   = q_dout[QW-1 -: TW];
  assign b_rad   = q_dout[RW-1:0];
  assign out_pop = pop && !empty;

  rmq_back #(.FRAC_BITS(FRAC_BITS), .RW(RW), .CAP(CAP)) u_back (
    .clk(clk), .rst(rst),
    .q_empty(q_empty), .q_tag(b_tag), .q_rad(b_rad), .q_pop(q_pop),
    .out_pop(out_pop), .res_v(res_v), .res(res)
  );

  rmq_outq #(.W($bits(rmq_result_t)), .DEPTH(OUT_DEPTH)) u_outq (
    .clk(clk), .rst(rst),
    .wr(res_v), .din(res), .pop(out_pop), .empty(empty), .dout(head)
  );

  assign quat_w       = head.w;
  assign quat_x       = head.x;
  assign quat_y       = head.y;
  assign quat_z       = head.z;
  assign branch_taken = head.br;
  assign degenerate   = head.deg;

endmodule

// ===== hdl/rmq_front.sv =====
// front end: branch choice, radicand and off-diagonal numerators
module rmq_front #(
  parameter int FRAC_BITS = 14,
  parameter int RW        = FRAC_BITS + 18
) (
  input  logic signed [rmq_pkg::ELEM_W-1:0] r00,
  input  logic signed [rmq_pkg::ELEM_W-1:0] r01,
  input  logic signed [rmq_pkg::ELEM_W-1:0] r02,
  input  logic signed [rmq_pkg::ELEM_W-1:0] r10,
  input  logic signed [rmq_pkg::ELEM_W-1:0] r11,
  input  logic signed [rmq_pkg::ELEM_W-1:0] r12,
  input  logic signed [rmq_pkg::ELEM_W-1:0] r20,
  input  logic signed [rmq_pkg::ELEM_W-1:0] r21,
  input  logic signed [rmq_pkg::ELEM_W-1:0] r22,
  output rmq_pkg::rmq_tag_t                 tag,
  output logic signed [RW-1:0]              rad
);
  import rmq_pkg::*;

  localparam logic signed [RW-1:0] ONE_R = RW'(1) << FRAC_BITS;

  logic signed [NUM_W-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
  logic signed [NUM_W-1:0] tr, d0, d1, d2, sel;

  always_comb begin
    e00 = NUM_W'(r00); e01 = NUM_W'(r01); e02 = NUM_W'(r02);
    e10 = NUM_W'(r10); e11 = NUM_W'(r11); e12 = NUM_W'(r12);
    e20 = NUM_W'(r20); e21 = NUM_W'(r21); e22 = NUM_W'(r22);
    tr = e00 + e11 + e22;
    d0 = e00 - e11 - e22;
    d1 = e11 - e00 - e22;
    d2 = e22 - e00 - e11;
    tag = '0;
    priority if (tr > 0) begin
      tag.br = BR_TRACE;
      sel    = tr;
      tag.n0 = e21 - e12;
      tag.n1 = e02 - e20;
      tag.n2 = e10 - e01;
    end else if (r00 > r11 && r00 > r22) begin
      tag.br = BR_X;
      sel    = d0;
      tag.n0 = e21 - e12;
      tag.n1 = e01 + e10;
      tag.n2 = e02 + e20;
    end else if (r11 > r22) begin
      tag.br = BR_Y;
      sel    = d1;
      tag.n0 = e02 - e20;
      tag.n1 = e01 + e10;
      tag.n2 = e12 + e21;
    end else begin
      tag.br = BR_Z;
      sel    = d2;
      tag.n0 = e10 - e01;
      tag.n1 = e02 + e20;
      tag.n2 = e12 + e21;
    end
    rad     = ONE_R + RW'(sel);
    tag.deg = (rad <= 0);
  end

endmodule

// ===== hdl/rmq_queue.sv =====
// short register queue between front and back ends
module rmq_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic         empty,
  output logic [W-1:0] dout
);
  import rmq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  store [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] cnt;
  logic          do_push, do_pop;

  assign full    = (cnt == CW'(DEPTH));
  assign empty   = (cnt == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

// ===== hdl/rmq_back.sv =====
// back end: pipelined square root, three pipelined dividers, saturation
module rmq_back #(
  parameter int FRAC_BITS = 14,
  parameter int RW        = FRAC_BITS + 18,
  parameter int CAP       = 65
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_empty,
  input  rmq_pkg::rmq_tag_t    q_tag,
  input  logic signed [RW-1:0] q_rad,
  output logic                 q_pop,
  input  logic                 out_pop,
  output logic                 res_v,
  output rmq_pkg::rmq_result_t res
);
  import rmq_pkg::*;

  localparam int SW = FRAC_BITS + 9;
  localparam int NW = 2 * SW;
  localparam int DW = FRAC_BITS + 18;
  localparam int UW = $clog2(CAP + 1);
  localparam int MW = NUM_W - 1;
  localparam logic [DW-1:0] ONE_Q = DW'(1) << FRAC_BITS;

  // credits cover everything issued and not yet popped at the output
  logic [UW-1:0] used;
  logic          issue;

  assign issue = !q_empty && (used < UW'(CAP));
  assign q_pop = issue;

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else begin
      unique case ({issue, out_pop})
        2'b10:   used <= used + 1'b1;
        2'b01:   used <= used - 1'b1;
        default: used <= used;
      endcase
    end
  end

  // square root, one result bit per stage
  logic           sq_v    [SW+1];
  rmq_tag_t       sq_tag  [SW+1];
  logic [SW-1:0]  sq_root [SW+1];
  logic [SW+1:0]  sq_rem  [SW+1];
  logic [NW-1:0]  sq_n    [SW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v[0] <= 1'b0;
    end else begin
      sq_v[0] <= issue;
    end
  end

  always_ff @(posedge clk) begin
    sq_tag[0]  <= q_tag;
    sq_root[0] <= '0;
    sq_rem[0]  <= '0;
    sq_n[0]    <= q_tag.deg ? '0 : {q_rad[RW-1:0], {FRAC_BITS{1'b0}}};
  end

  for (genvar i = 0; i < SW; i++) begin : g_sq
    logic [SW+1:0] cur, trial;
    logic          ge;
    assign cur   = {sq_rem[i][SW-1:0], sq_n[i][NW-1 -: 2]};
    assign trial = {sq_root[i], 2'b01};
    assign ge    = (cur >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[i+1] <= 1'b0;
      end else begin
        sq_v[i+1] <= sq_v[i];
      end
    end

    always_ff @(posedge clk) begin
      sq_tag[i+1]  <= sq_tag[i];
      sq_root[i+1] <= {sq_root[i][SW-2:0], ge};
      sq_rem[i+1]  <= ge ? cur - trial : cur;
      sq_n[i+1]    <= {sq_n[i][NW-3:0], 2'b00};
    end
  end

  // dividers: ((|num| << F) + s) / (2s), one quotient bit per stage
  logic           dv_v    [DW+1];
  rmq_tag_t       dv_tag  [DW+1];
  logic [SW:0]    dv_den  [DW+1];
  logic [DW-1:0]  dv_diag [DW+1];
  logic [DW-1:0]  dv_d    [DW+1][3];
  logic [DW-1:0]  dv_q    [DW+1][3];
  logic [SW+1:0]  dv_rem  [DW+1][3];

  logic [SW:0]    diag_raw;
  logic [MW-1:0]  mag [3];
  logic [SW-1:0]  s_root;

  always_comb begin
    s_root   = sq_root[SW];
    diag_raw = ({1'b0, s_root} + 1'b1) >> 1;
    mag[0]   = sq_tag[SW].n0[NUM_W-1] ? MW'(-sq_tag[SW].n0) : MW'(sq_tag[SW].n0);
    mag[1]   = sq_tag[SW].n1[NUM_W-1] ? MW'(-sq_tag[SW].n1) : MW'(sq_tag[SW].n1);
    mag[2]   = sq_tag[SW].n2[NUM_W-1] ? MW'(-sq_tag[SW].n2) : MW'(sq_tag[SW].n2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else begin
      dv_v[0] <= sq_v[SW];
    end
  end

  always_ff @(posedge clk) begin
    dv_tag[0]  <= sq_tag[SW];
    dv_den[0]  <= {s_root, 1'b0};
    dv_diag[0] <= (DW'(diag_raw) > ONE_Q) ? ONE_Q : DW'(diag_raw);
    for (int k = 0; k < 3; k++) begin
      dv_d[0][k]   <= ({DW'(mag[k])} << FRAC_BITS) + DW'(s_root);
      dv_q[0][k]   <= '0;
      dv_rem[0][k] <= '0;
    end
  end

  for (genvar j = 0; j < DW; j++) begin : g_dv
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[j+1] <= 1'b0;
      end else begin
        dv_v[j+1] <= dv_v[j];
      end
    end

    always_ff @(posedge clk) begin
      dv_tag[j+1]  <= dv_tag[j];
      dv_den[j+1]  <= dv_den[j];
      dv_diag[j+1] <= dv_diag[j];
    end

    for (genvar k = 0; k < 3; k++) begin : g_lane
      logic [SW+1:0] cur;
      logic          ge;
      assign cur = {dv_rem[j][k][SW:0], dv_d[j][k][DW-1]};
      assign ge  = (cur >= {1'b0, dv_den[j]});

      always_ff @(posedge clk) begin
        dv_rem[j+1][k] <= ge ? cur - {1'b0, dv_den[j]} : cur;
        dv_q[j+1][k]   <= {dv_q[j][k][DW-2:0], ge};
        dv_d[j+1][k]   <= {dv_d[j][k][DW-2:0], 1'b0};
      end
    end
  end

  // saturate, restore sign, place the parts by branch, zero degenerate results
  logic [ELEM_W-1:0]  part [3];
  logic [ELEM_W-1:0]  diag16;
  logic               neg  [3];
  rmq_result_t        res_next;

  always_comb begin
    logic [DW-1:0]     qm;
    logic signed [DW:0] val;
    neg[0] = dv_tag[DW].n0[NUM_W-1];
    neg[1] = dv_tag[DW].n1[NUM_W-1];
    neg[2] = dv_tag[DW].n2[NUM_W-1];
    for (int k = 0; k < 3; k++) begin
      qm      = (dv_q[DW][k] > ONE_Q) ? ONE_Q : dv_q[DW][k];
      val     = neg[k] ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
      part[k] = val[ELEM_W-1:0];
    end
    diag16       = dv_diag[DW][ELEM_W-1:0];
    res_next     = '0;
    res_next.br  = dv_tag[DW].br;
    res_next.deg = dv_tag[DW].deg;
    unique case (dv_tag[DW].br)
      BR_TRACE: begin
        res_next.w = diag16;  res_next.x = part[0];
        res_next.y = part[1]; res_next.z = part[2];
      end
      BR_X: begin
        res_next.w = part[0]; res_next.x = diag16;
        res_next.y = part[1]; res_next.z = part[2];
      end
      BR_Y: begin
        res_next.w = part[0]; res_next.x = part[1];
        res_next.y = diag16;  res_next.z = part[2];
      end
      default: begin
        res_next.w = part[0]; res_next.x = part[1];
        res_next.y = part[2]; res_next.z = diag16;
      end
    endcase
    if (dv_tag[DW].deg) begin
      res_next.w = '0;
      res_next.x = '0;
      res_next.y = '0;
      res_next.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_v <= 1'b0;
    end else begin
      res_v <= dv_v[DW];
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

  a_credit_bound: assert property (@(posedge clk) disable iff (rst) used <= UW'(CAP))
    else $error("credit count above capacity");
  a_res_holds_credit: assert property (@(posedge clk) disable iff (rst) res_v |-> used != '0)
    else $error("result with no credit outstanding");
  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    res_v && res.deg |-> res.w == '0 && res.x == '0 && res.y == '0 && res.z == '0)
    else $error("degenerate result not zeroed");

endmodule

// ===== hdl/rmq_outq.sv =====
// result queue: memory with a registered head entry
module rmq_outq #(
  parameter int W     = 8,
  parameter int DEPTH = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic         empty,
  output logic [W-1:0] dout
);
  import rmq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] cnt;
  logic          head_valid, head_free, load, bypass, mem_wr;

  assign empty     = !head_valid;
  assign head_free = !head_valid || pop;
  assign load      = head_free && (cnt != '0);
  assign bypass    = head_free && (cnt == '0) && wr;
  assign mem_wr    = wr && !bypass;

  always_ff @(posedge clk) begin
    if (mem_wr) begin
      mem[wr_ptr] <= din;
    end
    if (load) begin
      dout <= mem[rd_ptr];
    end else if (bypass) begin
      dout <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      cnt        <= '0;
      head_valid <= 1'b0;
    end else begin
      if (mem_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (load) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({mem_wr, load})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
      if (load || bypass) begin
        head_valid <= 1'b1;
      end else if (pop) begin
        head_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== dv/rotation_matrix_to_quaternion_tb.sv =====
// testbench for the rotation matrix to quaternion block with a queue-based scoreboard
module rotation_matrix_to_quaternion_tb;
  import rmq_pkg::*;

  localparam int FB = 14;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int N_RANDOM = 800;

  typedef struct {
    logic signed [15:0] w, x, y, z;
    br_t                br;
    logic               deg;
  } quat_t;

  typedef logic signed [15:0] mat_t [9];

  class quat_scoreboard;
    quat_t pending[$];
    int    errors;

    function automatic longint isqrt(longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
        if (n >= res + bitv) begin
          n -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    function automatic longint sat_one(longint v);
      longint one;
      one = longint'(1) << FB;
      if (v > one) return one;
      if (v < -one) return -one;
      return v;
    endfunction

    function automatic logic signed [15:0] scaled_div(longint num, longint s);
      longint mag, q;
      mag = num < 0 ? -num : num;
      q = ((mag << FB) + s) / (2 * s);
      return 16'(sat_one(num < 0 ? -q : q));
    endfunction

    function void note_matrix(mat_t m);
      longint e[9];
      longint tr, rad, s;
      logic signed [15:0] dg;
      quat_t q;
      foreach (e[i]) e[i] = m[i];
      tr = e[0] + e[4] + e[8];
      q = '{default: 0, br: BR_TRACE};
      if (tr > 0) begin
        q.br = BR_TRACE; rad = (1 << FB) + tr;
      end else if (e[0] > e[4] && e[0] > e[8]) begin
        q.br = BR_X; rad = (1 << FB) + e[0] - e[4] - e[8];
      end else if (e[4] > e[8]) begin
        q.br = BR_Y; rad = (1 << FB) + e[4] - e[0] - e[8];
      end else begin
        q.br = BR_Z; rad = (1 << FB) + e[8] - e[0] - e[4];
      end
      if (rad <= 0) begin
        q.deg = 1;
      end else begin
        s = isqrt(longint'(rad) << FB);
        dg = 16'(sat_one((s + 1) >>> 1));
        case (q.br)
          BR_TRACE: begin
            q.w = dg; q.x = scaled_div(e[7] - e[5], s);
            q.y = scaled_div(e[2] - e[6], s); q.z = scaled_div(e[3] - e[1], s);
          end
          BR_X: begin
            q.w = scaled_div(e[7] - e[5], s); q.x = dg;
            q.y = scaled_div(e[1] + e[3], s); q.z = scaled_div(e[2] + e[6], s);
          end
          BR_Y: begin
            q.w = scaled_div(e[2] - e[6], s); q.x = scaled_div(e[1] + e[3], s);
            q.y = dg; q.z = scaled_div(e[5] + e[7], s);
          end
          default: begin
            q.w = scaled_div(e[3] - e[1], s); q.x = scaled_div(e[2] + e[6], s);
            q.y = scaled_div(e[5] + e[7], s); q.z = dg;
          end
        endcase
      end
      pending.push_back(q);
    endfunction

    function void check_result(quat_t got);
      quat_t exp_q;
      if (pending.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
        return;
      end
      exp_q = pending.pop_front();
      if (got.w !== exp_q.w) begin
        $error("quat_w expected %0d actual %0d", exp_q.w, got.w); errors++;
      end
      if (got.x !== exp_q.x) begin
        $error("quat_x expected %0d actual %0d", exp_q.x, got.x); errors++;
      end
      if (got.y !== exp_q.y) begin
        $error("quat_y expected %0d actual %0d", exp_q.y, got.y); errors++;
      end
      if (got.z !== exp_q.z) begin
        $error("quat_z expected %0d actual %0d", exp_q.z, got.z); errors++;
      end
      if (got.br !== exp_q.br) begin
        $error("branch_taken expected %0d actual %0d", exp_q.br, got.br); errors++;
      end
      if (got.deg !== exp_q.deg) begin
        $error("degenerate expected %0d actual %0d", exp_q.deg, got.deg); errors++;
      end
    endfunction
  endclass

  logic clk, rst, push, pop;
  logic full, empty;
  logic signed [15:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
  logic signed [15:0] quat_w, quat_x, quat_y, quat_z;
  logic [1:0] branch_taken;
  logic degenerate;

  quat_scoreboard sb;
  bit sending_done;
  bit hold_off;
  int idle_cycles = 0;
  mat_t directed[$];

  rotation_matrix_to_quaternion #(.FRAC_BITS(FB)) uut (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .r00(r00), .r01(r01), .r02(r02), .r10(r10), .r11(r11), .r12(r12),
    .r20(r20), .r21(r21), .r22(r22),
    .empty(empty), .pop(pop),
    .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
    .branch_taken(branch_taken), .degenerate(degenerate)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic logic signed [15:0] rand_elem();
    case ($urandom_range(0, 5))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'($urandom);
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  // random signed permutation matrix scaled by 11585, with jitter on every element
  function automatic mat_t rand_rotation();
    mat_t m;
    int perm[3];
    int sg[3];
    int t, j;
    perm = '{0, 1, 2};
    for (int i = 2; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = perm[i]; perm[i] = perm[j]; perm[j] = t;
    end
    foreach (sg[i]) sg[i] = $urandom_range(0, 1) ? 1 : -1;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        m[r*3+c] = 16'((c == perm[r] ? sg[r] * 11585 : 0) +
                       $signed($urandom_range(0, 2 * 8000)) - 8000);
    return m;
  endfunction

  // push stays high across back-to-back requests
  task automatic send_matrix(mat_t m);
    int gap;
    gap = $urandom_range(0, 9);
    if (gap != 0) begin
      push <= 0;
      repeat (gap) @(negedge clk);
    end
    {r00, r01, r02, r10, r11, r12, r20, r21, r22} =
      {m[0], m[1], m[2], m[3], m[4], m[5], m[6], m[7], m[8]};
    push <= 1;
    do @(posedge clk); while (full);
    sb.note_matrix(m);
    @(negedge clk);
  endtask

  initial begin
    mat_t m;
    sb = new();
    push = 0; pop = 0; rst = 1;
    {r00, r01, r02, r10, r11, r12, r20, r21, r22} = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 0;
    // identity, each branch, ties and extremes
    directed.push_back('{16384, 0, 0, 0, 16384, 0, 0, 0, 16384});
    directed.push_back('{16384, 0, 0, 0, -16384, 0, 0, 0, -16384});
    directed.push_back('{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384});
    directed.push_back('{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384});
    directed.push_back('{0, 0, 0, 0, 0, 0, 0, 0, 0});
    directed.push_back('{-16384, 0, 0, 0, -16384, 0, 0, 0, -16384});
    directed.push_back('{-8192, 16384, 16384, 16384, -8192, 16384, 16384, 16384, -8192});
    directed.push_back('{-16384, -16384, -16384, -16384, -16384, -16384,
                         -16384, -16384, -16384});
    directed.push_back('{-32768, 32767, -32768, 32767, -32768, 32767,
                         -32768, 32767, -32768});
    directed.push_back('{32767, -32768, 32767, -32768, 32767, -32768,
                         32767, -32768, 32767});
    directed.push_back('{-32768, 0, 0, 0, -32768, 0, 0, 0, -32768});
    directed.push_back('{1, 16384, -16384, -16384, 0, 16384, 16384, -16384, 0});
    directed.push_back('{0, 0, 16384, 0, 16384, 0, -16384, 0, 0});
    directed.push_back('{0, -16384, 0, 16384, 0, 0, 0, 0, 16384});
    directed.push_back('{-1, 16384, 16384, 16384, -1, 16384, 16384, 16384, -1});
    foreach (directed[i]) send_matrix(directed[i]);
    for (int i = 0; i < N_RANDOM; i++) begin
      if ($urandom_range(0, 3) != 0) m = rand_rotation();
      else foreach (m[k]) m[k] = rand_elem();
      send_matrix(m);
    end
    push <= 0;
    sending_done = 1;
  end

  // receiver, with one long hold-off so the block backs up to full
  initial begin
    bit stalled;
    int gap;
    stalled = 0;
    hold_off = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!stalled && sb.pending.size() > 20) begin
        stalled = 1;
        pop <= 0;
        repeat (1500) @(negedge clk);
      end
      gap = $urandom_range(0, 9);
      if (gap != 0) begin
        pop <= 0;
        repeat (gap) @(negedge clk);
      end
      pop <= 1;
      do @(posedge clk); while (empty);
      sb.check_result('{quat_w, quat_x, quat_y, quat_z, br_t'(branch_taken), degenerate});
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("rotation_matrix_to_quaternion_tb: FAIL");
        $finish;
      end
    end
  end

  initial begin
    wait (sending_done);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (2 * FB + 40) @(posedge clk);
    if (sb.errors == 0 && !(empty === 1'b0)) $display("rotation_matrix_to_quaternion_tb: PASS");
    else $display("rotation_matrix_to_quaternion_tb: FAIL");
    $finish;
  end

endmodule
